### design/kiu_pkg.sv
// Package with shared sizes, command codes and controller/datapath types.
`default_nettype none
package kiu_pkg;

   localparam int SOURCES     = 4;
   localparam int LIST_DEPTH  = 16;
   localparam int STORE_SIZE  = SOURCES * LIST_DEPTH;
   localparam int SRC_W       = $clog2(SOURCES);
   localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int ADDR_W      = $clog2(STORE_SIZE);
   localparam int COORD_W     = 31;
   localparam int SOURCE_ID_W = 2;

   // Input item command codes.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_LOAD,
      DP_SCAN,
      DP_DRAIN,
      DP_PICK
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [SRC_W-1:0] scan_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic need_emit;
      logic out_free;
      logic best_valid;
   } dp_status_type;

endpackage
`default_nettype wire

### design/kiu_if.sv
// Valid/ready channel interfaces for the request and response items.
`default_nettype none
interface kiu_req_if;
   import kiu_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [SOURCE_ID_W-1:0] source_id;
   logic [COORD_W-1:0]     interval_beg;
   logic [COORD_W-1:0]     interval_end;

   modport source (output valid, cmd, source_id, interval_beg, interval_end, input ready);
   modport sink   (input valid, cmd, source_id, interval_beg, interval_end, output ready);
   modport mon    (input valid, ready, cmd, source_id, interval_beg, interval_end);
endinterface

interface kiu_rsp_if;
   import kiu_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] union_beg;
   logic [COORD_W-1:0] union_end;
   logic               is_empty;
   logic               is_last;
   logic               overflow_seen;
   logic               order_error;

   modport source (output valid, union_beg, union_end, is_empty, is_last, overflow_seen,
                   order_error, input ready);
   modport sink   (input valid, union_beg, union_end, is_empty, is_last, overflow_seen,
                   order_error, output ready);
   modport mon    (input valid, ready, union_beg, union_end, is_empty, is_last,
                   overflow_seen, order_error);
endinterface
`default_nettype wire

### design/kiu_ctrl.sv
// Controller state machine sequencing loads, head scans and merge picks.
`default_nettype none
module kiu_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_cmd,
   output logic                 req_ready,
   input  kiu_pkg::dp_status_type status,
   output kiu_pkg::dp_cmd_type  cmd
);
   import kiu_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK
   } state_type;

   state_type        state_ff;
   logic [SRC_W-1:0] scan_ff;
   logic             proceed;

   // A pick that produces a result must find the output register free.
   assign proceed = !status.need_emit || status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_cmd == CMD_CLOSE) begin
                  state_ff <= ST_SCAN;
                  scan_ff  <= '0;
               end
            end
            ST_SCAN: begin
               if (scan_ff == SRC_W'(SOURCES - 1)) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  scan_ff <= SRC_W'(scan_ff + 1'b1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_PICK;
            end
            ST_PICK: begin
               if (proceed) begin
                  scan_ff <= '0;
                  if (status.best_valid) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.scan_idx = scan_ff;
      unique case (state_ff)
         ST_IDLE:  cmd.op = (req_valid && req_cmd == CMD_LOAD) ? DP_LOAD : DP_IDLE;
         ST_SCAN:  cmd.op = DP_SCAN;
         ST_DRAIN: cmd.op = DP_DRAIN;
         ST_PICK:  cmd.op = proceed ? DP_PICK : DP_IDLE;
         default:  cmd.op = DP_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### design/kiu_dpath.sv
// Datapath: interval store, per-source counters, head scan, union build and output register.
`default_nettype none
module kiu_dpath (
   input  wire                             clock,
   input  wire                             reset,
   input  kiu_pkg::dp_cmd_type             cmd,
   output kiu_pkg::dp_status_type          status,
   input  wire [kiu_pkg::SOURCE_ID_W-1:0]  load_source_id,
   input  wire [kiu_pkg::COORD_W-1:0]      load_beg,
   input  wire [kiu_pkg::COORD_W-1:0]      load_end,
   input  wire                             rsp_ready,
   output logic                            rsp_valid,
   output logic [kiu_pkg::COORD_W-1:0]     rsp_union_beg,
   output logic [kiu_pkg::COORD_W-1:0]     rsp_union_end,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_last,
   output logic                            rsp_overflow_seen,
   output logic                            rsp_order_error
);
   import kiu_pkg::*;

   // Interval store, one region of LIST_DEPTH entries per source.
   logic [COORD_W-1:0] mem_beg [STORE_SIZE];
   logic [COORD_W-1:0] mem_end [STORE_SIZE];

   logic [CNT_W-1:0]   count_ff    [SOURCES];
   logic [CNT_W-1:0]   head_ff     [SOURCES];
   logic [COORD_W-1:0] last_beg_ff [SOURCES];

   logic               overflow_ff;
   logic               order_ff;
   logic               started_ff;
   logic [COORD_W-1:0] ubeg_ff;
   logic [COORD_W-1:0] run_end_ff;

   logic               rd_valid_ff;
   logic [SRC_W-1:0]   rd_src_ff;
   logic [COORD_W-1:0] rd_beg_ff;
   logic [COORD_W-1:0] rd_end_ff;

   logic               best_valid_ff;
   logic [SRC_W-1:0]   best_src_ff;
   logic [COORD_W-1:0] best_beg_ff;
   logic [COORD_W-1:0] best_end_ff;

   logic               out_valid_ff;
   logic [COORD_W-1:0] out_beg_ff;
   logic [COORD_W-1:0] out_end_ff;
   logic               out_empty_ff;
   logic               out_last_ff;
   logic               out_ovf_ff;
   logic               out_ord_ff;

   logic               is_load;
   logic               src_ok;
   logic [SRC_W-1:0]   sel_src;
   logic [CNT_W-1:0]   sel_count;
   logic [CNT_W-1:0]   sel_head;
   logic               full;
   logic [COORD_W-1:0] ld_beg;
   logic [COORD_W-1:0] ld_end;
   logic [ADDR_W-1:0]  base;
   logic [ADDR_W-1:0]  addr;
   logic               ld_we;
   logic               order_hit;
   logic               rd_hit;
   logic               take_rd;
   logic               pick;
   logic               gap;

   assign is_load   = (cmd.op == DP_LOAD);
   assign src_ok    = (32'(load_source_id) < 32'(SOURCES));
   assign sel_src   = is_load ? SRC_W'(load_source_id) : cmd.scan_idx;
   assign sel_count = count_ff[sel_src];
   assign sel_head  = head_ff[sel_src];
   assign full      = (sel_count >= CNT_W'(LIST_DEPTH));

   // Reversed intervals are stored with their ends swapped.
   assign ld_beg = (load_beg > load_end) ? load_end : load_beg;
   assign ld_end = (load_beg > load_end) ? load_beg : load_end;

   assign base = ADDR_W'(sel_src) * ADDR_W'(LIST_DEPTH);
   assign addr = is_load ? ADDR_W'(base + ADDR_W'(sel_count[IDX_W-1:0]))
                         : ADDR_W'(base + ADDR_W'(sel_head[IDX_W-1:0]));

   assign ld_we     = is_load && src_ok && !full;
   assign order_hit = ld_we && (sel_count != '0) && (ld_beg < last_beg_ff[sel_src]);
   assign rd_hit    = (cmd.op == DP_SCAN) && (sel_head < sel_count);

   // Strict compare keeps the lowest source on equal starts.
   assign take_rd = rd_valid_ff && (!best_valid_ff || rd_beg_ff < best_beg_ff);
   assign pick    = (cmd.op == DP_PICK);
   assign gap     = started_ff && (best_beg_ff > run_end_ff);

   assign status.need_emit  = !best_valid_ff || gap;
   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.best_valid = best_valid_ff;

   always_ff @(posedge clock) begin
      if (ld_we) begin
         mem_beg[addr] <= ld_beg;
         mem_end[addr] <= ld_end;
      end
      rd_beg_ff <= mem_beg[addr];
      rd_end_ff <= mem_end[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SOURCES; s++) begin
            count_ff[s] <= '0;
            head_ff[s]  <= '0;
         end
         overflow_ff   <= 1'b0;
         order_ff      <= 1'b0;
         started_ff    <= 1'b0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= rd_hit;
         // A pick that finishes a union interval loads the output register.
         if (pick && (!best_valid_ff || gap)) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (ld_we) begin
            count_ff[sel_src] <= CNT_W'(sel_count + 1'b1);
         end
         if (is_load && src_ok && full) begin
            overflow_ff <= 1'b1;
         end
         if (order_hit) begin
            order_ff <= 1'b1;
         end
         if (take_rd) begin
            best_valid_ff <= 1'b1;
         end
         if (pick) begin
            best_valid_ff <= 1'b0;
            if (best_valid_ff) begin
               head_ff[best_src_ff] <= CNT_W'(head_ff[best_src_ff] + 1'b1);
               started_ff           <= 1'b1;
            end else begin
               // All lists exhausted: final result goes out, contig state clears.
               for (int s = 0; s < SOURCES; s++) begin
                  count_ff[s] <= '0;
                  head_ff[s]  <= '0;
               end
               overflow_ff <= 1'b0;
               order_ff    <= 1'b0;
               started_ff  <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         last_beg_ff[sel_src] <= ld_beg;
      end
      rd_src_ff <= sel_src;
      if (take_rd) begin
         best_src_ff <= rd_src_ff;
         best_beg_ff <= rd_beg_ff;
         best_end_ff <= rd_end_ff;
      end
      if (pick) begin
         if (best_valid_ff) begin
            if (!started_ff || gap) begin
               ubeg_ff    <= best_beg_ff;
               run_end_ff <= best_end_ff;
            end else if (best_end_ff > run_end_ff) begin
               run_end_ff <= best_end_ff;
            end
            if (gap) begin
               out_beg_ff   <= ubeg_ff;
               out_end_ff   <= run_end_ff;
               out_empty_ff <= 1'b0;
               out_last_ff  <= 1'b0;
               out_ovf_ff   <= overflow_ff;
               out_ord_ff   <= order_ff;
            end
         end else begin
            out_beg_ff   <= started_ff ? ubeg_ff : '0;
            out_end_ff   <= started_ff ? run_end_ff : '0;
            out_empty_ff <= !started_ff;
            out_last_ff  <= 1'b1;
            out_ovf_ff   <= overflow_ff;
            out_ord_ff   <= order_ff;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_union_beg     = out_beg_ff;
   assign rsp_union_end     = out_end_ff;
   assign rsp_is_empty      = out_empty_ff;
   assign rsp_is_last       = out_last_ff;
   assign rsp_overflow_seen = out_ovf_ff;
   assign rsp_order_error   = out_ord_ff;

endmodule
`default_nettype wire

### design/kway_interval_union_core.sv
// Top level of the k-way interval union block: controller, datapath and channel hookup.
// A load item causes no result. A close item starts the merge; with N stored intervals it
// runs (N + 1) merge picks, each made of a scan of every source head through the single read
// port of the interval store, a drain step and a pick step, plus response stalls.
// Reset is synchronous and clears counts, heads and flags; the interval store is not cleared.
`default_nettype none
module kway_interval_union_core (
   input  wire        clock,
   input  wire        reset,
   kiu_req_if.sink    req_ch,
   kiu_rsp_if.source  rsp_ch
);
   import kiu_pkg::*;

   // The controller and the datapath talk only through these two bundles.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller accepts items only while idle. Loads are absorbed in that
   // same cycle; a close starts the merge, which walks the source heads in
   // order, keeps the smallest start (lowest source on a tie) and then either
   // extends the union being built or hands a finished one to the output
   // register. The output register lets loads of the next contig come in
   // while the final result of the previous one still waits to be taken.
   kiu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // The datapath owns the interval store, the per-source counters and the
   // union registers, and it drives the response channel directly.
   kiu_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .load_source_id    (req_ch.source_id),
      .load_beg          (req_ch.interval_beg),
      .load_end          (req_ch.interval_end),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_union_beg     (rsp_ch.union_beg),
      .rsp_union_end     (rsp_ch.union_end),
      .rsp_is_empty      (rsp_ch.is_empty),
      .rsp_is_last       (rsp_ch.is_last),
      .rsp_overflow_seen (rsp_ch.overflow_seen),
      .rsp_order_error   (rsp_ch.order_error)
   );

endmodule
`default_nettype wire

### design/kiu_checker.sv
// Port-level checker for the interval union core and its bind statement.
`default_nettype none
module kiu_checker (
   input wire         clock,
   input wire         reset,
   kiu_req_if.sink    req_ch,
   kiu_rsp_if.source  rsp_ch
);
   import kiu_pkg::*;

   // A close keeps the block busy for at least the following cycle.
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.cmd == CMD_CLOSE |=> !req_ch.ready)
      else $error("request ready right after a close item");

   // An empty contig gives one final result with zero coordinates.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_empty |->
         rsp_ch.is_last && rsp_ch.union_beg == '0 && rsp_ch.union_end == '0)
      else $error("malformed empty result");

   // Union intervals never come out reversed.
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.union_beg <= rsp_ch.union_end)
      else $error("union start above union end");

   // A stalled result stays valid and holds its coordinates and last flag.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         rsp_ch.valid && $stable(rsp_ch.union_beg) && $stable(rsp_ch.union_end) &&
         $stable(rsp_ch.is_last))
      else $error("stalled result changed");

endmodule

bind kway_interval_union_core kiu_checker u_kiu_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
`default_nettype wire

### sim/kway_interval_union_core_test.sv
// Self-checking testbench for the k-way interval union block with a built-in union predictor.
`default_nettype none
module kway_interval_union_core_test;
   import kiu_pkg::*;

   // Largest coordinate, kept 32 bits wide so that sums can be clamped.
   localparam logic [31:0] MAX_COORD = 32'h7FFF_FFFF;
   // A close over a full store takes (STORE_SIZE + 1) picks, each a scan of every source, a drain and a pick.
   localparam int TAIL_CYCLES = 2 * (STORE_SIZE + 1) * (SOURCES + 2);
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 100;

   typedef struct packed {
      logic                   cmd;
      logic [SOURCE_ID_W-1:0] source_id;
      logic [COORD_W-1:0]     interval_beg;
      logic [COORD_W-1:0]     interval_end;
   } req_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] union_beg;
      logic [COORD_W-1:0] union_end;
      logic               is_empty;
      logic               is_last;
      logic               overflow_seen;
      logic               order_error;
   } union_item_type;

   logic clock;
   logic reset;

   kiu_req_if req_bus ();
   kiu_rsp_if rsp_bus ();

   kway_interval_union_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Items waiting to be driven, and union intervals waiting to come out.
   req_item_type   req_backlog[$];
   union_item_type expected_unions[$];

   int req_total;
   int req_accepted;
   int err_cnt;
   int cycle_cnt;
   logic req_fire;
   req_item_type next_req;

   // Predictor copy of the per-source interval lists and the contig flags.
   logic [COORD_W-1:0] list_lo [SOURCES][LIST_DEPTH];
   logic [COORD_W-1:0] list_hi [SOURCES][LIST_DEPTH];
   int                 list_fill [SOURCES];
   int                 merge_pos [SOURCES];
   logic               contig_overflow;
   logic               contig_misorder;

   // Per-source start cursor used to build sorted random lists.
   logic [31:0] gen_cursor [SOURCES];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Empties every list and clears the flags, as a close or a reset does.
   task automatic clear_lists();
      for (int s = 0; s < SOURCES; s++) begin
         list_fill[s] = 0;
         merge_pos[s] = 0;
      end
      contig_overflow = 1'b0;
      contig_misorder = 1'b0;
   endtask

   // Returns the source whose next unread interval starts lowest; ties go to
   // the lowest source number. Returns -1 once every list is used up.
   function automatic int lowest_head();
      int best;
      logic [COORD_W-1:0] best_beg;
      best = -1;
      best_beg = '0;
      for (int s = 0; s < SOURCES; s++) begin
         if (merge_pos[s] < list_fill[s]) begin
            if (best < 0 || list_lo[s][merge_pos[s]] < best_beg) begin
               best = s;
               best_beg = list_lo[s][merge_pos[s]];
            end
         end
      end
      return best;
   endfunction

   task automatic push_union(input logic [COORD_W-1:0] ubeg, input logic [COORD_W-1:0] uend,
                             input logic empty, input logic last);
      union_item_type u;
      u.union_beg     = ubeg;
      u.union_end     = uend;
      u.is_empty      = empty;
      u.is_last       = last;
      u.overflow_seen = contig_overflow;
      u.order_error   = contig_misorder;
      expected_unions.push_back(u);
   endtask

   // Applies one accepted item to the predictor. A load only updates the
   // lists; a close walks the k-way merge and queues the union intervals.
   task automatic track_request(input req_item_type it);
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      logic [COORD_W-1:0] run_beg;
      logic [COORD_W-1:0] run_end;
      int src;
      int fill;
      int pick;
      if (it.cmd == CMD_LOAD) begin
         src = int'(it.source_id);
         if (src >= SOURCES) return;
         // A reversed interval is stored with its ends swapped.
         lo = (it.interval_beg > it.interval_end) ? it.interval_end : it.interval_beg;
         hi = (it.interval_beg > it.interval_end) ? it.interval_beg : it.interval_end;
         fill = list_fill[src];
         if (fill >= LIST_DEPTH) begin
            contig_overflow = 1'b1;
         end else begin
            if (fill > 0 && lo < list_lo[src][fill - 1]) contig_misorder = 1'b1;
            list_lo[src][fill] = lo;
            list_hi[src][fill] = hi;
            list_fill[src] = fill + 1;
         end
      end else begin
         pick = lowest_head();
         if (pick < 0) begin
            push_union('0, '0, 1'b1, 1'b1);
         end else begin
            run_beg = list_lo[pick][merge_pos[pick]];
            run_end = list_hi[pick][merge_pos[pick]];
            merge_pos[pick]++;
            pick = lowest_head();
            while (pick >= 0) begin
               lo = list_lo[pick][merge_pos[pick]];
               hi = list_hi[pick][merge_pos[pick]];
               merge_pos[pick]++;
               // A start past the running end closes the current union interval;
               // a touching start still extends it.
               if (lo > run_end) begin
                  push_union(run_beg, run_end, 1'b0, 1'b0);
                  run_beg = lo;
                  run_end = hi;
               end else if (hi > run_end) begin
                  run_end = hi;
               end
               pick = lowest_head();
            end
            push_union(run_beg, run_end, 1'b0, 1'b1);
         end
         clear_lists();
      end
   endtask

   function automatic void check_union(input union_item_type exp, input union_item_type act);
      if (act.union_beg !== exp.union_beg) begin
         $error("union_beg expected %0d actual %0d", exp.union_beg, act.union_beg);
         err_cnt++;
      end
      if (act.union_end !== exp.union_end) begin
         $error("union_end expected %0d actual %0d", exp.union_end, act.union_end);
         err_cnt++;
      end
      if (act.is_empty !== exp.is_empty) begin
         $error("is_empty expected %0d actual %0d", exp.is_empty, act.is_empty);
         err_cnt++;
      end
      if (act.is_last !== exp.is_last) begin
         $error("is_last expected %0d actual %0d", exp.is_last, act.is_last);
         err_cnt++;
      end
      if (act.overflow_seen !== exp.overflow_seen) begin
         $error("overflow_seen expected %0d actual %0d", exp.overflow_seen, act.overflow_seen);
         err_cnt++;
      end
      if (act.order_error !== exp.order_error) begin
         $error("order_error expected %0d actual %0d", exp.order_error, act.order_error);
         err_cnt++;
      end
   endfunction

   task automatic add_load(input int src, input logic [COORD_W-1:0] ibeg,
                           input logic [COORD_W-1:0] iend);
      req_item_type it;
      it.cmd          = CMD_LOAD;
      it.source_id    = src[SOURCE_ID_W-1:0];
      it.interval_beg = ibeg;
      it.interval_end = iend;
      req_backlog.push_back(it);
   endtask

   task automatic add_close();
      req_item_type it;
      it.cmd          = CMD_CLOSE;
      it.source_id    = SOURCE_ID_W'($urandom_range(0, SOURCES - 1));
      it.interval_beg = COORD_W'($urandom());
      it.interval_end = COORD_W'($urandom());
      req_backlog.push_back(it);
   endtask

   // One random contig. Most loads follow a sorted start per source, with
   // lengths that make overlaps and touching intervals common; some loads are
   // raw noise that brings reversed ends, descending starts and every bit.
   task automatic gen_contig(output int n_items);
      int kind;
      int n_loads;
      int src;
      int fixed_src;
      int span;
      logic [31:0] base;
      logic [31:0] b;
      logic [31:0] e;
      kind = $urandom_range(0, 99);
      span = ($urandom_range(0, 1) != 0) ? 40 : 32'h00FF_FFFF;
      base = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 32'h7000_0000);
      for (int s = 0; s < SOURCES; s++) gen_cursor[s] = base + $urandom_range(0, span);
      fixed_src = $urandom_range(0, SOURCES - 1);
      if (kind < 10) n_loads = 0;
      else if (kind < 18) n_loads = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
      else n_loads = $urandom_range(1, 8);
      for (int k = 0; k < n_loads; k++) begin
         // The long contigs pile onto one source so that its list fills up.
         src = (kind < 18) ? fixed_src : $urandom_range(0, SOURCES - 1);
         if ($urandom_range(0, 99) < 12) begin
            b = $urandom() & MAX_COORD;
            e = $urandom() & MAX_COORD;
         end else begin
            b = gen_cursor[src] + $urandom_range(0, span);
            if (b > MAX_COORD) b = MAX_COORD;
            e = b + $urandom_range(0, 2 * span);
            if (e > MAX_COORD) e = MAX_COORD;
            gen_cursor[src] = b;
         end
         add_load(src, b[COORD_W-1:0], e[COORD_W-1:0]);
      end
      add_close();
      n_items = n_loads + 1;
   endtask

   // The run has three stretches by progress: sender idles more lightly than
   // the receiver, then the reverse, then both run flat out.
   function automatic int run_phase();
      return (req_accepted * 3) / req_total;
   endfunction

   function automatic int sender_idle_pct();
      case (run_phase())
         0: return 37;
         1: return 62;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (run_phase())
         0: return 62;
         1: return 37;
         default: return 0;
      endcase
   endfunction

   // Driver: everything the testbench drives changes on the falling edge.
   // A new item goes out only when the bus is empty or the last one was taken,
   // so valid gets a single assignment per edge and stays high across
   // back-to-back items.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_fire) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
               next_req = req_backlog.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.cmd          <= next_req.cmd;
               req_bus.source_id    <= next_req.source_id;
               req_bus.interval_beg <= next_req.interval_beg;
               req_bus.interval_end <= next_req.interval_end;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   // Monitor: both handshakes are sampled on the rising edge. An accepted
   // item feeds the predictor before any result of that edge is checked.
   always @(posedge clock) begin
      req_item_type   seen_req;
      union_item_type seen_union;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            seen_req.cmd          = req_bus.cmd;
            seen_req.source_id    = req_bus.source_id;
            seen_req.interval_beg = req_bus.interval_beg;
            seen_req.interval_end = req_bus.interval_end;
            track_request(seen_req);
            req_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_union.union_beg     = rsp_bus.union_beg;
            seen_union.union_end     = rsp_bus.union_end;
            seen_union.is_empty      = rsp_bus.is_empty;
            seen_union.is_last       = rsp_bus.is_last;
            seen_union.overflow_seen = rsp_bus.overflow_seen;
            seen_union.order_error   = rsp_bus.order_error;
            if (expected_unions.size() == 0) begin
               $error("unexpected result union_beg %0d union_end %0d",
                      seen_union.union_beg, seen_union.union_end);
               err_cnt++;
            end else begin
               check_union(expected_unions.pop_front(), seen_union);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("kway_interval_union_core_test: FAIL");
         $finish;
      end
   end

   initial begin
      int n;
      int random_items;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_LOAD;
      req_bus.source_id    = '0;
      req_bus.interval_beg = '0;
      req_bus.interval_end = '0;
      rsp_bus.ready        = 1'b0;
      req_fire             = 1'b0;
      req_accepted         = 0;
      err_cnt              = 0;
      cycle_cnt            = 0;
      clear_lists();

      // A close with nothing loaded gives the single empty result.
      add_close();
      // Coordinate extremes; the last load is reversed and gets swapped.
      add_load(0, '0, MAX_COORD[COORD_W-1:0]);
      add_load(1, MAX_COORD[COORD_W-1:0], MAX_COORD[COORD_W-1:0]);
      add_load(3, MAX_COORD[COORD_W-1:0], '0);
      add_close();
      // Equal starts on sources 0 and 3, a touching interval that extends the
      // union, and a one-past gap that starts a new one.
      add_load(0, 31'd10, 31'd20);
      add_load(3, 31'd10, 31'd15);
      add_load(1, 31'd20, 31'd30);
      add_load(2, 31'd31, 31'd40);
      add_close();
      // One list filled past its depth, with one descending start inside it.
      for (int k = 0; k <= LIST_DEPTH; k++) begin
         add_load(2, (k == 5) ? 31'd3 : COORD_W'(k * 8), (k == 5) ? 31'd7 : COORD_W'(k * 8 + 4));
      end
      add_close();

      // Random contigs top the directed items up to the planned total.
      random_items = req_backlog.size();
      while (random_items < RANDOM_ITEMS) begin
         gen_contig(n);
         random_items += n;
      end
      req_total = req_backlog.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Both counters move only on the rising edge, so the falling edge
      // sees them settled.
      while (!(req_accepted == req_total && expected_unions.size() == 0)) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);

      if (err_cnt == 0) begin
         $display("kway_interval_union_core_test: PASS");
      end else begin
         $display("kway_interval_union_core_test: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
